// ----- sv/dwsd_pkg.sv -----
// Shared types and constants for the double-word signed divider.
// No dependencies; every other file imports this package.
`default_nettype none

package dwsd_pkg;

    localparam int MAX_WORD_BITS = 64;
    // One restoring step per bit of the 128-bit dividend register
    localparam int DIV_STEPS     = 128;

    // Sign modes
    localparam logic [1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [1:0] MODE_ONES     = 2'd1;
    localparam logic [1:0] MODE_TWOS     = 2'd2;
    localparam logic [1:0] MODE_SIGNMAG  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Register indexes
    localparam logic REG_WORD_SIZE = 1'b0;
    localparam logic REG_SIGN_MODE = 1'b1;

    localparam logic [6:0] WORD_SIZE_RESET = 7'd64;
    localparam logic [1:0] SIGN_MODE_RESET = MODE_TWOS;

    typedef struct packed {
        logic        action;
        logic [63:0] divisor;
        logic [63:0] dividend_high;
        logic [63:0] dividend_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_word;
        logic [1:0]  status;
        logic        carry;
    } out_item_t;

    // Item state while it walks through the divide stages
    typedef struct packed {
        logic         action;
        logic         dneg;
        logic         vneg;
        logic [63:0]  dmag;
        logic [63:0]  rem;
        logic [127:0] rq;     // dividend bits shift out at the top, quotient bits in at the bottom
    } div_stage_t;

    function automatic logic [63:0] word_mask(input logic [5:0] nm1);
        word_mask = ~((~64'd0 << nm1) << 1);
    endfunction

endpackage

`default_nettype wire

// ----- sv/dwsd_decode.sv -----
// Operand decode: sign/magnitude split of divisor and dividend, then
// assembly of the 2n-bit dividend magnitude. Two register stages; uses dwsd_pkg.
`default_nettype none

module dwsd_decode
    import dwsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire logic [5:0] nm1,
    input  wire logic [1:0] mode,
    input  wire logic       in_vld,
    input  wire in_item_t   in_item,
    output logic            out_vld,
    output div_stage_t      out_stage
);

    logic        a_vld_reg;
    logic        a_action_reg, a_dneg_reg, a_vneg_reg;
    logic [63:0] a_dmag_reg, a_hi_reg, a_lo_reg;
    logic        a_dneg_next, a_vneg_next;
    logic [63:0] a_dmag_next, a_hi_next, a_lo_next;
    logic        b_vld_reg;
    div_stage_t  b_stage_reg;
    div_stage_t  b_stage_next;
    logic [63:0] mask;
    logic [63:0] dw, hw, lw;
    logic [6:0]  n7;

    always_comb
    begin
        mask = word_mask(nm1);
        dw   = in_item.divisor & mask;
        hw   = in_item.dividend_high & mask;
        lw   = in_item.dividend_low & mask;

        a_dneg_next = 1'b0;
        a_dmag_next = dw;
        if (mode != MODE_UNSIGNED && in_item.divisor[nm1])
        begin
            a_dneg_next = 1'b1;
            unique case (mode)
                MODE_TWOS: a_dmag_next = (64'd0 - dw) & mask;
                MODE_ONES: a_dmag_next = (~dw) & mask;
                default:   a_dmag_next = dw & (mask >> 1);
            endcase
        end

        a_vneg_next = 1'b0;
        a_hi_next   = hw;
        a_lo_next   = lw;
        if (mode != MODE_UNSIGNED && hw[nm1])
        begin
            a_vneg_next = 1'b1;
            unique case (mode)
                MODE_TWOS:
                begin
                    a_lo_next = (64'd0 - lw) & mask;
                    a_hi_next = (~hw + {63'd0, (lw == 64'd0)}) & mask;
                end
                MODE_ONES:
                begin
                    a_lo_next = (~lw) & mask;
                    a_hi_next = (~hw) & mask;
                end
                default:
                begin
                    a_hi_next = hw & (mask >> 1);
                end
            endcase
        end
    end

    always_comb
    begin
        n7 = {1'b0, nm1} + 7'd1;
        b_stage_next.action = a_action_reg;
        b_stage_next.dneg   = a_dneg_reg;
        b_stage_next.vneg   = a_vneg_reg;
        b_stage_next.dmag   = a_dmag_reg;
        b_stage_next.rem    = 64'd0;
        b_stage_next.rq     = {64'd0, a_lo_reg} | ({64'd0, a_hi_reg} << n7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_action_reg <= in_item.action;
            a_dneg_reg   <= a_dneg_next;
            a_vneg_reg   <= a_vneg_next;
            a_dmag_reg   <= a_dmag_next;
            a_hi_reg     <= a_hi_next;
            a_lo_reg     <= a_lo_next;
            b_stage_reg  <= b_stage_next;
        end
    end

    assign out_vld   = b_vld_reg;
    assign out_stage = b_stage_reg;

endmodule

`default_nettype wire

// ----- sv/dwsd_step.sv -----
// One restoring-division step with its stage register.
// Uses dwsd_pkg.
`default_nettype none

module dwsd_step
    import dwsd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  wire logic in_vld,
    input  wire div_stage_t in_stage,
    output logic       out_vld,
    output div_stage_t out_stage
);

    logic       vld_reg;
    div_stage_t stage_reg;
    div_stage_t stage_next;
    logic [64:0] trial;
    logic [64:0] diff;

    always_comb
    begin
        trial      = {in_stage.rem, in_stage.rq[127]};
        diff       = trial - {1'b0, in_stage.dmag};
        stage_next = in_stage;
        if (!diff[64])
        begin
            stage_next.rem = diff[63:0];
            stage_next.rq  = {in_stage.rq[126:0], 1'b1};
        end
        else
        begin
            stage_next.rem = trial[63:0];
            stage_next.rq  = {in_stage.rq[126:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            stage_reg <= stage_next;
    end

    assign out_vld   = vld_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

// ----- sv/dwsd_encode.sv -----
// Result stage: zero/overflow checks and sign-mode encoding into the
// output register. Uses dwsd_pkg.
`default_nettype none

module dwsd_encode
    import dwsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire logic [5:0] nm1,
    input  wire logic [1:0] mode,
    input  wire logic       in_vld,
    input  wire div_stage_t in_stage,
    output logic            out_vld,
    output out_item_t       out_item
);

    logic        vld_reg;
    out_item_t   item_reg;
    out_item_t   item_next;
    logic [63:0] mask, lim, qh, ql, m;
    logic        neg, qneg, fits;

    always_comb
    begin
        mask = word_mask(nm1);
        lim  = 64'd1 << nm1;
        qh   = in_stage.rq[127:64];
        ql   = in_stage.rq[63:0];
        qneg = in_stage.dneg ^ in_stage.vneg;

        if (mode == MODE_UNSIGNED)
            fits = (qh == 64'd0) && ((ql & ~mask) == 64'd0);
        else if (qneg && mode == MODE_TWOS)
            fits = (qh == 64'd0) && (ql <= lim);
        else
            fits = (qh == 64'd0) && (ql < lim);

        if (in_stage.action)
        begin
            m   = in_stage.rem;
            neg = in_stage.vneg;
        end
        else
        begin
            m   = ql;
            neg = qneg;
        end

        item_next.status = ST_OK;
        item_next.carry  = 1'b0;
        if (m == 64'd0 || !neg || mode == MODE_UNSIGNED)
            item_next.result_word = m & mask;
        else
        begin
            unique case (mode)
                MODE_TWOS: item_next.result_word = (64'd0 - m) & mask;
                MODE_ONES: item_next.result_word = (~m) & mask;
                default:   item_next.result_word = (m | lim) & mask;
            endcase
        end

        if (in_stage.dmag == 64'd0)
        begin
            item_next.result_word = 64'd0;
            item_next.status      = ST_DIV_ZERO;
        end
        else if (!in_stage.action)
        begin
            if (!fits)
            begin
                item_next.result_word = 64'd0;
                item_next.status      = ST_OVERFLOW;
            end
            else
                item_next.carry = (in_stage.rem != 64'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

`default_nettype wire

// ----- sv/double_word_signed_divider.sv -----
// Double-word signed divider: divides a 2n-bit dividend (high and low
// n-bit words) by an n-bit divisor in the configured sign mode.
//
// Input channel in_valid/in_stall carries in_data (action, divisor,
// dividend_high, dividend_low); output channel out_valid/out_stall carries
// out_data (result_word, status, carry). An item is taken on an edge with
// valid high and stall low. Each item gives exactly one result.
// From the accepting edge, the item passes two decode stages, 128 divide
// stages of one restoring step each, and the result register, which drives
// out_valid. Throughput is one item per cycle while the pipeline is not frozen.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises; bubbles still fill as long as the output slot is free.
// Reset empties the pipeline and sets word_size to 64 and sign_mode to
// two's complement. Write cfg_we/cfg_index/cfg_wdata only while no item
// is in flight: index 0 is word_size, index 1 is sign_mode.
// Depends on dwsd_pkg, dwsd_decode, dwsd_step and dwsd_encode.
`default_nettype none

module double_word_signed_divider
    import dwsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [6:0] cfg_wdata
);

    logic [6:0] word_size_reg;
    logic [1:0] sign_mode_reg;
    logic [5:0] nm1;
    logic       adv;
    logic       vld [0:DIV_STEPS];
    div_stage_t stg [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_size_reg <= WORD_SIZE_RESET;
            sign_mode_reg <= SIGN_MODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WORD_SIZE: word_size_reg <= cfg_wdata;
                REG_SIGN_MODE: sign_mode_reg <= cfg_wdata[1:0];
            endcase
        end
    end

    // Clamp word size to 1..64, kept as n-1
    always_comb
    begin
        if (word_size_reg == 7'd0)
            nm1 = 6'd0;
        else if (word_size_reg > 7'(MAX_WORD_BITS))
            nm1 = 6'(MAX_WORD_BITS - 1);
        else
            nm1 = 6'(word_size_reg - 7'd1);
    end

    // Advance everything unless a finished item is held at the output
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    dwsd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .nm1       (nm1),
        .mode      (sign_mode_reg),
        .in_vld    (in_valid),
        .in_item   (in_data),
        .out_vld   (vld[0]),
        .out_stage (stg[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        dwsd_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_vld    (vld[i]),
            .in_stage  (stg[i]),
            .out_vld   (vld[i+1]),
            .out_stage (stg[i+1])
        );
    end

    dwsd_encode u_encode (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .nm1      (nm1),
        .mode     (sign_mode_reg),
        .in_vld   (vld[DIV_STEPS]),
        .in_stage (stg[DIV_STEPS]),
        .out_vld  (out_valid),
        .out_item (out_data)
    );

endmodule

`default_nettype wire
